// File: rtl/kbc_pkg.sv
// ----------------------------------------------------------------------------
// kbc_pkg: shared definitions for the keyboard burst classifier
// Field widths, event and reason codes, register indexes, history commands
// and the small helper functions for the modifier test and the age check.
// ----------------------------------------------------------------------------
package kbc_pkg;

    localparam int KEY_W      = 25;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 48;
    localparam int WIN_W      = 26;
    localparam int REASON_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int HELD_SLOTS_DEF    = 16;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [REASON_W-1:0] REASON_NONE = 2'd0;
    localparam logic [REASON_W-1:0] REASON_PAW  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_HOLD = 2'd2;
    localparam logic [REASON_W-1:0] REASON_WALK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PAW_KEYS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEATS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DISTINCT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_UNIQUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_PRESSES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_WINDOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_WINDOW   = 3'd6;

    localparam logic [4:0]       PAW_KEYS_RST      = 5'd4;
    localparam logic [5:0]       HOLD_REPEATS_RST  = 6'd8;
    localparam logic [5:0]       HOLD_DISTINCT_RST = 6'd2;
    localparam logic [5:0]       WALK_UNIQUE_RST   = 6'd8;
    localparam logic [5:0]       WALK_PRESSES_RST  = 6'd12;
    localparam logic [WIN_W-1:0] HOLD_WINDOW_RST   = 26'd2000000;
    localparam logic [WIN_W-1:0] WALK_WINDOW_RST   = 26'd1000000;

    localparam logic [KEY_W-1:0] MOD_FIRST = 25'h1000020;
    localparam logic [KEY_W-1:0] MOD_LAST  = 25'h1000026;
    localparam logic [KEY_W-1:0] MOD_ALTGR = 25'h1001103;

    localparam int HIST_CMD_W = 3;
    localparam logic [HIST_CMD_W-1:0] HC_IDLE       = 3'd0;
    localparam logic [HIST_CMD_W-1:0] HC_PRUNE      = 3'd1;
    localparam logic [HIST_CMD_W-1:0] HC_APPEND     = 3'd2;
    localparam logic [HIST_CMD_W-1:0] HC_SCAN_START = 3'd3;
    localparam logic [HIST_CMD_W-1:0] HC_SCAN       = 3'd4;

    localparam int HELD_OP_W = 2;
    localparam logic [HELD_OP_W-1:0] HO_NONE   = 2'd0;
    localparam logic [HELD_OP_W-1:0] HO_INSERT = 2'd1;
    localparam logic [HELD_OP_W-1:0] HO_REMOVE = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [KEY_W-1:0]  k;
        logic              flag;
    } hist_entry_t;

    typedef struct packed {
        logic prune_done;
        logic scan_done;
    } hist_stat_t;

    function automatic logic is_modifier(input logic [KEY_W-1:0] k);
        return ((k >= MOD_FIRST) && (k <= MOD_LAST)) || (k == MOD_ALTGR);
    endfunction

    // An entry is too old when its time plus the window is still before now.
    function automatic logic too_old(input logic [TIME_W-1:0] t,
                                     input logic [WIN_W-1:0]  w,
                                     input logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {{(TIME_W - WIN_W + 1){1'b0}}, w};
        return sum < {1'b0, now};
    endfunction

endpackage

// File: rtl/keyboard_burst_classifier_core.sv
// ----------------------------------------------------------------------------
// keyboard_burst_classifier_core: classifies key events into burst reasons
// Keeps the held-key set and press and repeat histories, and returns one
// reason per key event: none, paw press, hold-sit or walk burst.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_key_code, s_kind, s_timestamp_us
//  m_        out        m_valid/m_ready    m_reason
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A request goes from acceptance through pruning, the store update, the paw check,
// the repeat and press scans and the output state before its result is loaded;
// pruning runs until both histories are pruned, and each scan rotates the valid
// part of its cell chain once.
// Paw press results skip both scans; modifiers and releases skip evaluation.
// Reset is synchronous and active low; it empties the held set and both
// histories and loads the register defaults. A stalled result sits in the
// output register while the next request is already accepted and worked on.
//
module keyboard_burst_classifier_core #(
    parameter int HISTORY_DEPTH = kbc_pkg::HISTORY_DEPTH_DEF,
    parameter int HELD_SLOTS    = kbc_pkg::HELD_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kbc_pkg::KEY_W-1:0]       s_key_code,
    input  logic [kbc_pkg::KIND_W-1:0]      s_kind,
    input  logic [kbc_pkg::TIME_W-1:0]      s_timestamp_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kbc_pkg::REASON_W-1:0]    m_reason,
    input  logic                            cfg_we,
    input  logic [kbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int HW = $clog2(HELD_SLOTS + 1);
    localparam int TW = (CW > 6) ? CW : 6;
    localparam int PW = (HW > 5) ? HW : 5;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRUNE  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_PAW    = 3'd3;
    localparam logic [2:0] S_SCANR  = 3'd4;
    localparam logic [2:0] S_SCANP  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [4:0]                paw_reg;
    logic [5:0]                hold_rep_reg, hold_dist_reg, walk_uniq_reg, walk_cnt_reg;
    logic [kbc_pkg::WIN_W-1:0] hold_win_reg, walk_win_reg, max_win;

    // The captured request.
    logic [kbc_pkg::KEY_W-1:0]  key_reg;
    logic [kbc_pkg::KIND_W-1:0] kind_reg;
    logic [kbc_pkg::TIME_W-1:0] now_reg;

    logic [kbc_pkg::REASON_W-1:0] reason_reg, reason_next;
    logic                         m_valid_reg, m_valid_next;

    logic [kbc_pkg::HIST_CMD_W-1:0] press_cmd, repeat_cmd;
    logic [kbc_pkg::HELD_OP_W-1:0]  held_op;
    kbc_pkg::hist_stat_t            p_stat, r_stat;
    logic [CW-1:0]                  p_count, p_dist, p_fill, r_count, r_dist, r_fill;
    logic [HW-1:0]                  held_cnt;

    logic is_mod, out_free, hold_hit, walk_hit, paw_hit;

    assign max_win  = (hold_win_reg > walk_win_reg) ? hold_win_reg : walk_win_reg;
    assign is_mod   = kbc_pkg::is_modifier(key_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign paw_hit  = PW'(held_cnt) >= PW'(paw_reg);
    assign hold_hit = (TW'(r_count) >= TW'(hold_rep_reg)) &&
                      (TW'(r_dist) >= TW'(hold_dist_reg));
    assign walk_hit = (TW'(p_dist) >= TW'(walk_uniq_reg)) &&
                      (TW'(p_count) >= TW'(walk_cnt_reg));

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paw_reg       <= kbc_pkg::PAW_KEYS_RST;
            hold_rep_reg  <= kbc_pkg::HOLD_REPEATS_RST;
            hold_dist_reg <= kbc_pkg::HOLD_DISTINCT_RST;
            walk_uniq_reg <= kbc_pkg::WALK_UNIQUE_RST;
            walk_cnt_reg  <= kbc_pkg::WALK_PRESSES_RST;
            hold_win_reg  <= kbc_pkg::HOLD_WINDOW_RST;
            walk_win_reg  <= kbc_pkg::WALK_WINDOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kbc_pkg::REG_PAW_KEYS:      paw_reg       <= cfg_wdata[4:0];
                kbc_pkg::REG_HOLD_REPEATS:  hold_rep_reg  <= cfg_wdata[5:0];
                kbc_pkg::REG_HOLD_DISTINCT: hold_dist_reg <= cfg_wdata[5:0];
                kbc_pkg::REG_WALK_UNIQUE:   walk_uniq_reg <= cfg_wdata[5:0];
                kbc_pkg::REG_WALK_PRESSES:  walk_cnt_reg  <= cfg_wdata[5:0];
                kbc_pkg::REG_HOLD_WINDOW:   hold_win_reg  <= cfg_wdata;
                kbc_pkg::REG_WALK_WINDOW:   walk_win_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the request when it is accepted.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg  <= s_key_code;
            kind_reg <= s_kind;
            now_reg  <= s_timestamp_us;
        end
    end

    // Sequencer: prune, update the stores, then the three rules in order.
    always_comb begin
        state_next   = state_reg;
        reason_next  = reason_reg;
        m_valid_next = m_valid_reg && !m_ready;
        press_cmd    = kbc_pkg::HC_IDLE;
        repeat_cmd   = kbc_pkg::HC_IDLE;
        held_op      = kbc_pkg::HO_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PRUNE;
                end
            end
            S_PRUNE: begin
                press_cmd  = kbc_pkg::HC_PRUNE;
                repeat_cmd = kbc_pkg::HC_PRUNE;
                if (p_stat.prune_done && r_stat.prune_done) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // Modifiers, releases and the unused kind give reason none.
                reason_next = kbc_pkg::REASON_NONE;
                state_next  = S_OUT;
                if (!is_mod) begin
                    if (kind_reg == kbc_pkg::KIND_PRESS) begin
                        held_op    = kbc_pkg::HO_INSERT;
                        press_cmd  = kbc_pkg::HC_APPEND;
                        state_next = S_PAW;
                    end else if (kind_reg == kbc_pkg::KIND_REPEAT) begin
                        repeat_cmd = kbc_pkg::HC_APPEND;
                        state_next = S_PAW;
                    end else if (kind_reg == kbc_pkg::KIND_RELEASE) begin
                        held_op = kbc_pkg::HO_REMOVE;
                    end
                end
            end
            S_PAW: begin
                repeat_cmd = kbc_pkg::HC_SCAN_START;
                if (paw_hit) begin
                    reason_next = kbc_pkg::REASON_PAW;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_SCANR;
                end
            end
            S_SCANR: begin
                repeat_cmd = kbc_pkg::HC_SCAN;
                if (r_stat.scan_done) begin
                    if (hold_hit) begin
                        reason_next = kbc_pkg::REASON_HOLD;
                        state_next  = S_OUT;
                    end else begin
                        press_cmd  = kbc_pkg::HC_SCAN_START;
                        state_next = S_SCANP;
                    end
                end
            end
            S_SCANP: begin
                press_cmd = kbc_pkg::HC_SCAN;
                if (p_stat.scan_done) begin
                    reason_next = walk_hit ? kbc_pkg::REASON_WALK : kbc_pkg::REASON_NONE;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The working reason holds still while a finished result waits to be loaded.
    always_ff @(posedge aclk) begin
        if (state_reg != S_OUT) begin
            reason_reg <= reason_next;
        end
    end

    logic [kbc_pkg::REASON_W-1:0] out_reason_reg;

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            out_reason_reg <= reason_reg;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_reason = out_reason_reg;

    kbc_held #(
        .SLOTS (HELD_SLOTS)
    ) u_held (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (held_op),
        .key     (key_reg),
        .count   (held_cnt)
    );

    kbc_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (press_cmd),
        .now       (now_reg),
        .prune_win (max_win),
        .scan_win  (walk_win_reg),
        .key_in    (key_reg),
        .stat      (p_stat),
        .count     (p_count),
        .distinct  (p_dist),
        .fill      (p_fill)
    );

    kbc_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_repeat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (repeat_cmd),
        .now       (now_reg),
        .prune_win (max_win),
        .scan_win  (hold_win_reg),
        .key_in    (key_reg),
        .stat      (r_stat),
        .count     (r_count),
        .distinct  (r_dist),
        .fill      (r_fill)
    );

    // An accepted request always starts with the pruning phase.
    a_accept_prunes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_PRUNE)
        else $error("accepted request did not enter pruning");

    // Distinct keys never outnumber counted entries, and no history overfills.
    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_dist <= r_count) && (p_dist <= p_count) &&
        (r_fill <= CW'(HISTORY_DEPTH)) && (p_fill <= CW'(HISTORY_DEPTH)))
        else $error("scan or fill count out of range");

    // A finished result is loaded into the output register when it is free.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && out_free |=> m_valid && state_reg == S_IDLE)
        else $error("finished result was not presented");

endmodule

// File: rtl/kbc_hist_cell.sv
// ----------------------------------------------------------------------------
// kbc_hist_cell: one entry of a history chain
// Holds a time, a key and a window flag; loads from its neighbor or from a
// new entry, and compares its key against the probe key at the chain head.
// ----------------------------------------------------------------------------
module kbc_hist_cell (
    input  logic                 aclk,
    input  logic                 ld,
    input  logic                 sel_new,
    input  kbc_pkg::hist_entry_t new_entry,
    input  kbc_pkg::hist_entry_t nbr_entry,
    input  logic [kbc_pkg::KEY_W-1:0] probe,
    output kbc_pkg::hist_entry_t q,
    output logic                 match
);

    kbc_pkg::hist_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (ld) begin
            entry_reg <= sel_new ? new_entry : nbr_entry;
        end
    end

    assign q     = entry_reg;
    assign match = entry_reg.flag && (entry_reg.k == probe);

endmodule

// File: rtl/kbc_history.sv
// ----------------------------------------------------------------------------
// kbc_history: time-ordered event history as a chain of cells
// Oldest entry sits in cell 0. Pruning shifts the chain toward the head; a
// scan rotates the valid part once, counting window entries and distinct keys.
// ----------------------------------------------------------------------------
module kbc_history #(
    parameter int DEPTH = kbc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [kbc_pkg::HIST_CMD_W-1:0]   cmd,
    input  logic [kbc_pkg::TIME_W-1:0]       now,
    input  logic [kbc_pkg::WIN_W-1:0]        prune_win,
    input  logic [kbc_pkg::WIN_W-1:0]        scan_win,
    input  logic [kbc_pkg::KEY_W-1:0]        key_in,
    output kbc_pkg::hist_stat_t              stat,
    output logic [$clog2(DEPTH+1)-1:0]       count,
    output logic [$clog2(DEPTH+1)-1:0]       distinct,
    output logic [$clog2(DEPTH+1)-1:0]       fill
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] dist_reg, dist_next;

    kbc_pkg::hist_entry_t q [DEPTH];
    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     earlier;
    kbc_pkg::hist_entry_t new_entry;
    kbc_pkg::hist_entry_t head_wrap;

    logic          head_in_scan, prune_done, scan_done, full;
    logic          shift, rotate, do_wr, any_match;
    logic [IW-1:0] wr_idx;
    logic [CW-1:0] boundary;

    assign head_in_scan = !kbc_pkg::too_old(q[0].t, scan_win, now);
    assign prune_done   = (fill_reg == '0) || !kbc_pkg::too_old(q[0].t, prune_win, now);
    assign scan_done    = (step_reg == fill_reg);
    assign full         = (fill_reg == CW'(DEPTH));

    assign shift  = ((cmd == kbc_pkg::HC_PRUNE) && !prune_done) ||
                    ((cmd == kbc_pkg::HC_APPEND) && full);
    assign rotate = (cmd == kbc_pkg::HC_SCAN) && !scan_done;
    assign do_wr  = (cmd == kbc_pkg::HC_APPEND);
    assign wr_idx = full ? IW'(DEPTH - 1) : fill_reg[IW-1:0];

    assign boundary  = fill_reg - step_reg;
    assign new_entry = '{t: now, k: key_in, flag: 1'b0};
    assign head_wrap = '{t: q[0].t, k: q[0].k, flag: head_in_scan};

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        kbc_pkg::hist_entry_t nbr;
        logic                 wr_here;

        if (j == DEPTH - 1) begin : g_last
            assign nbr = (rotate && (fill_reg == CW'(j + 1))) ? head_wrap : q[j];
        end else begin : g_mid
            assign nbr = (rotate && (fill_reg == CW'(j + 1))) ? head_wrap : q[j+1];
        end

        assign wr_here    = do_wr && (wr_idx == IW'(j));
        assign earlier[j] = (CW'(j) >= boundary) && (CW'(j) < fill_reg);

        kbc_hist_cell u_cell (
            .aclk      (aclk),
            .ld        (shift || rotate || wr_here),
            .sel_new   (wr_here),
            .new_entry (new_entry),
            .nbr_entry (nbr),
            .probe     (q[0].k),
            .q         (q[j]),
            .match     (match[j])
        );
    end

    assign any_match = |(match & earlier);

    always_comb begin
        fill_next  = fill_reg;
        step_next  = step_reg;
        count_next = count_reg;
        dist_next  = dist_reg;
        if ((cmd == kbc_pkg::HC_PRUNE) && !prune_done) begin
            fill_next = fill_reg - 1'b1;
        end
        if ((cmd == kbc_pkg::HC_APPEND) && !full) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd == kbc_pkg::HC_SCAN_START) begin
            step_next  = '0;
            count_next = '0;
            dist_next  = '0;
        end
        if (rotate) begin
            step_next = step_reg + 1'b1;
            if (head_in_scan) begin
                count_next = count_reg + 1'b1;
                if (!any_match) begin
                    dist_next = dist_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            step_reg  <= '0;
            count_reg <= '0;
            dist_reg  <= '0;
        end else begin
            fill_reg  <= fill_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            dist_reg  <= dist_next;
        end
    end

    assign stat.prune_done = prune_done;
    assign stat.scan_done  = scan_done;
    assign count           = count_reg;
    assign distinct        = dist_reg;
    assign fill            = fill_reg;

endmodule

// File: rtl/kbc_held.sv
// ----------------------------------------------------------------------------
// kbc_held: set of non-modifier keys now held down
// Slots with valid bits; insert takes the lowest free slot, remove clears the
// matching slot. A running count of held keys is kept alongside.
// ----------------------------------------------------------------------------
module kbc_held #(
    parameter int SLOTS = kbc_pkg::HELD_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [kbc_pkg::HELD_OP_W-1:0]  op,
    input  logic [kbc_pkg::KEY_W-1:0]      key,
    output logic [$clog2(SLOTS+1)-1:0]     count
);

    localparam int HW = $clog2(SLOTS + 1);

    logic [kbc_pkg::KEY_W-1:0] keys_reg [SLOTS];
    logic [SLOTS-1:0]          valid_reg, valid_next;
    logic [HW-1:0]             count_reg, count_next;
    logic [SLOTS-1:0]          hit, free, first_free;
    logic                      do_ins;

    for (genvar i = 0; i < SLOTS; i++) begin : g_hit
        assign hit[i] = valid_reg[i] && (keys_reg[i] == key);
    end

    assign free       = ~valid_reg;
    assign first_free = free & (~free + 1'b1);
    assign do_ins     = (op == kbc_pkg::HO_INSERT) && !(|hit) && (|free);

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (do_ins) begin
            valid_next = valid_reg | first_free;
            count_next = count_reg + 1'b1;
        end
        if ((op == kbc_pkg::HO_REMOVE) && (|hit)) begin
            valid_next = valid_reg & ~hit;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_keys
        always_ff @(posedge aclk) begin
            if (do_ins && first_free[i]) begin
                keys_reg[i] <= key;
            end
        end
    end

    assign count = count_reg;

endmodule
